[rtl/core/reader_writer_lock_table_top_macros.svh]
// Assertion macros for the reader-writer lock table.
// No dependencies; included by the top level only.
`ifndef READER_WRITER_LOCK_TABLE_TOP_MACROS_SVH
`define READER_WRITER_LOCK_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define RWLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwlt: same-cycle check failed");

`define RWLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwlt: next-cycle check failed");

`else

`define RWLT_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define RWLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/rwlt_pkg.sv]
// Shared types and constants of the reader-writer lock table.
// No dependencies; imported by every module of the block.
package rwlt_pkg;

    localparam int NUM_LOCKS      = 64;
    localparam int NUM_REQUESTERS = 16;

    localparam int OP_W           = 2;
    localparam int LOCK_W         = 6;
    localparam int REQ_W          = 4;
    localparam int ERR_W          = 2;
    localparam int CNT_W          = 5;
    localparam int LOCK_COUNT_W   = 7;
    localparam logic [LOCK_COUNT_W-1:0] LOCK_COUNT_RESET = 7'd64;

    localparam int CMD_DEPTH      = 4;
    localparam int CMD_PTR_W      = 2;
    localparam int OUT_DEPTH      = 2;
    localparam int OUT_PTR_W      = 1;

    typedef enum logic [OP_W-1:0] {
        OP_ACQ_RD = 2'd0,
        OP_ACQ_WR = 2'd1,
        OP_REL_RD = 2'd2,
        OP_REL_WR = 2'd3
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_RANGE      = 2'd1,
        ERR_NOT_READER = 2'd2,
        ERR_NOT_WRITER = 2'd3
    } err_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic [LOCK_W-1:0] lock_index;
        logic [REQ_W-1:0]  requester;
        logic              last;
        logic              range_err;
    } cmd_t;

    typedef struct packed {
        logic                      write_locked;
        logic [REQ_W-1:0]          writer_id;
        logic [NUM_REQUESTERS-1:0] reader_set;
        logic [CNT_W-1:0]          reader_count;
    } entry_t;

    typedef struct packed {
        logic granted;
        err_t error_code;
        logic all_granted;
        logic request_done;
    } result_t;

    typedef struct packed {
        logic                 busy;
        logic [OUT_PTR_W:0]   out_count;
    } back_status_t;

endpackage

[rtl/core/reader_writer_lock_table_top.sv]
// Reader-writer lock table top level.
// Depends on rwlt_pkg, rwlt_front, rwlt_back and the macros header.
// An item goes from the command queue through the table read register to the result queue.
// The back end takes a new item only after the last one is read, updated and queued.
// Command queue holds 4 items, result queue 2; each side stalls on its own.
// Reset: all locks free (per-entry valid bits cleared), lock_count 64, queues empty.
`include "reader_writer_lock_table_top_macros.svh"

module reader_writer_lock_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [rwlt_pkg::LOCK_COUNT_W-1:0] cfg_wr_data,
    input  logic                              push,
    output logic                              full,
    input  logic [rwlt_pkg::OP_W-1:0]         operation,
    input  logic [rwlt_pkg::LOCK_W-1:0]       lock_index,
    input  logic [rwlt_pkg::REQ_W-1:0]        requester,
    input  logic                              last_of_request,
    output logic                              empty,
    input  logic                              pop,
    output logic                              granted,
    output logic [rwlt_pkg::ERR_W-1:0]        error_code,
    output logic                              all_granted,
    output logic                              request_done
);
    import rwlt_pkg::*;

    logic         cmd_valid;
    logic         cmd_ready;
    cmd_t         cmd;
    result_t      result;
    back_status_t status;

    rwlt_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .lock_index      (lock_index),
        .requester       (requester),
        .last_of_request (last_of_request),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_ready       (cmd_ready)
    );

    rwlt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .status    (status)
    );

    assign granted      = result.granted;
    assign error_code   = result.error_code;
    assign all_granted  = result.all_granted;
    assign request_done = result.request_done;

    `RWLT_ASSERT_NEXT(a_take_starts_exec, clk, rst_n, cmd_valid && cmd_ready, status.busy)
    `RWLT_ASSERT_NOW(a_error_not_granted, clk, rst_n, !empty && error_code != ERR_NONE, !granted)
    `RWLT_ASSERT_NOW(a_all_granted_on_last, clk, rst_n, !empty && all_granted, request_done)
    `RWLT_ASSERT_NOW(a_empty_count, clk, rst_n, empty, status.out_count == '0)

endmodule

[rtl/core/rwlt_front.sv]
// Front end: input transfer, lock_count register, range classification, command queue.
// Depends on rwlt_pkg.
module rwlt_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [rwlt_pkg::LOCK_COUNT_W-1:0] cfg_wr_data,
    input  logic                              push,
    output logic                              full,
    input  logic [rwlt_pkg::OP_W-1:0]         operation,
    input  logic [rwlt_pkg::LOCK_W-1:0]       lock_index,
    input  logic [rwlt_pkg::REQ_W-1:0]        requester,
    input  logic                              last_of_request,
    output logic                              cmd_valid,
    output rwlt_pkg::cmd_t                    cmd,
    input  logic                              cmd_ready
);
    import rwlt_pkg::*;

    logic [LOCK_COUNT_W-1:0] lock_count_reg;
    cmd_t                    queue_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CMD_PTR_W:0]      count_reg, count_next;
    logic                    push_ok;
    logic                    pop_ok;
    logic                    range_err;
    cmd_t                    cmd_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_count_reg <= LOCK_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            lock_count_reg <= cfg_wr_data;
        end
    end

    // index past min(lock_count, NUM_LOCKS) or an unknown requester
    always_comb
    begin
        range_err = ({1'b0, lock_index} >= lock_count_reg)
                 || ({1'b0, lock_index} >= LOCK_COUNT_W'(NUM_LOCKS))
                 || ({1'b0, requester} >= (REQ_W+1)'(NUM_REQUESTERS));
        cmd_in.op         = op_t'(operation);
        cmd_in.lock_index = lock_index;
        cmd_in.requester  = requester;
        cmd_in.last       = last_of_request;
        cmd_in.range_err  = range_err;
    end

    assign full      = (count_reg == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_mem[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_ok && pop_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            queue_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[rtl/core/rwlt_back.sv]
// Back end: lock table memory, read-modify-write sequencer, request tracking, result queue.
// Depends on rwlt_pkg.
module rwlt_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  rwlt_pkg::cmd_t         cmd,
    output logic                   cmd_ready,
    output logic                   empty,
    input  logic                   pop,
    output rwlt_pkg::result_t      result,
    output rwlt_pkg::back_status_t status
);
    import rwlt_pkg::*;

    entry_t               table_mem [NUM_LOCKS];
    logic [NUM_LOCKS-1:0] valid_reg;
    entry_t               rdata_reg;
    logic                 rvalid_reg;
    cmd_t                 cmd_reg;
    back_state_t          state_reg, state_next;
    logic                 ok_reg, ok_next;

    result_t              out_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] out_wr_reg, out_rd_reg;
    logic [OUT_PTR_W:0]   out_count_reg, out_count_next;
    logic                 out_full;
    logic                 out_push;
    logic                 out_pop;

    logic                 take;
    logic                 finish;
    entry_t               cur;
    entry_t               upd;
    logic                 is_reader;
    logic [NUM_REQUESTERS-1:0] who_bit;
    logic [CNT_W-1:0]     cnt_dec;
    logic                 granted;
    err_t                 err;
    logic                 ok_upd;
    result_t              res;

    assign out_full = (out_count_reg == (OUT_PTR_W+1)'(OUT_DEPTH));
    assign take     = (state_reg == ST_IDLE) && cmd_valid;
    assign finish   = (state_reg == ST_EXEC) && !out_full;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cmd_valid) state_next = ST_EXEC;
            ST_EXEC: if (!out_full) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        cmd_ready = 1'b0;
        out_push  = 1'b0;
        case (state_reg)
            ST_IDLE: cmd_ready = 1'b1;
            ST_EXEC: out_push  = !out_full;
            default: cmd_ready = 1'b0;
        endcase
    end

    // entry never written reads as a free lock
    always_comb
    begin
        cur       = rvalid_reg ? rdata_reg : '0;
        who_bit   = NUM_REQUESTERS'(1) << cmd_reg.requester;
        is_reader = (cur.reader_set & who_bit) != '0;
        cnt_dec   = (cur.reader_count != '0) ? cur.reader_count - 1'b1 : cur.reader_count;
        upd       = cur;
        granted   = 1'b0;
        err       = ERR_NONE;
        if (cmd_reg.range_err)
        begin
            err = ERR_RANGE;
        end
        else
        begin
            case (cmd_reg.op)
                OP_ACQ_RD:
                begin
                    if (!(cur.reader_count == '0 && cur.write_locked))
                    begin
                        if (!is_reader)
                        begin
                            upd.reader_set   = cur.reader_set | who_bit;
                            upd.reader_count = cur.reader_count + 1'b1;
                        end
                        granted = 1'b1;
                    end
                end
                OP_ACQ_WR:
                begin
                    // sole reader may upgrade
                    if ((cur.reader_count == '0
                         || (cur.reader_count == CNT_W'(1) && is_reader))
                        && (!cur.write_locked || cur.writer_id == cmd_reg.requester))
                    begin
                        upd.write_locked = 1'b1;
                        upd.writer_id    = cmd_reg.requester;
                        granted          = 1'b1;
                    end
                end
                OP_REL_RD:
                begin
                    if (!is_reader)
                    begin
                        err = ERR_NOT_READER;
                    end
                    else
                    begin
                        upd.reader_set   = cur.reader_set & ~who_bit;
                        upd.reader_count = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            upd.write_locked = 1'b0;
                        end
                        granted = 1'b1;
                    end
                end
                OP_REL_WR:
                begin
                    if (!cur.write_locked || cur.writer_id != cmd_reg.requester)
                    begin
                        err = ERR_NOT_WRITER;
                    end
                    else
                    begin
                        upd.write_locked = 1'b0;
                        upd.writer_id    = '0;
                        granted          = 1'b1;
                    end
                end
                default: err = ERR_NONE;
            endcase
        end

        ok_upd = ok_reg;
        if ((cmd_reg.op inside {OP_ACQ_RD, OP_ACQ_WR}) && !granted)
        begin
            ok_upd = 1'b0;
        end
        ok_next = ok_reg;
        if (finish)
        begin
            ok_next = cmd_reg.last ? 1'b1 : ok_upd;
        end

        res.granted      = granted;
        res.error_code   = err;
        res.all_granted  = cmd_reg.last & ok_upd;
        res.request_done = cmd_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ok_reg    <= 1'b1;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
            if (finish && granted)
            begin
                valid_reg[cmd_reg.lock_index] <= 1'b1;
            end
        end
    end

    // table memory: read on take, write back on a granted finish
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rdata_reg  <= table_mem[cmd.lock_index];
            rvalid_reg <= valid_reg[cmd.lock_index];
            cmd_reg    <= cmd;
        end
        if (finish && granted)
        begin
            table_mem[cmd_reg.lock_index] <= upd;
        end
    end

    // result queue
    assign empty   = (out_count_reg == '0);
    assign out_pop = pop && !empty;
    assign result  = out_mem[out_rd_reg];

    always_comb
    begin
        out_count_next = out_count_reg;
        if (out_push && !out_pop)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (!out_push && out_pop)
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (out_push)
            begin
                out_wr_reg <= out_wr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_reg <= out_rd_reg + 1'b1;
            end
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_mem[out_wr_reg] <= res;
        end
    end

    assign status.busy      = (state_reg == ST_EXEC);
    assign status.out_count = out_count_reg;

endmodule

[tb/sv/reader_writer_lock_table_top_tb.sv]
// Testbench for reader_writer_lock_table_top: directed and random lock traffic pushed
// through the command queue, each popped result checked against a lock table predictor.
// Depends on rwlt_pkg and the reader_writer_lock_table_top RTL.
module reader_writer_lock_table_top_tb;
    import rwlt_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 305;
    localparam int NUM_PHASES      = 6;
    localparam int unsigned LOCK_COUNT_PLAN [NUM_PHASES] = '{1, 64, 6, 2, 40, 64};

    typedef struct {
        op_t               op;
        logic [LOCK_W-1:0] idx;
        logic [REQ_W-1:0]  who;
        logic              last;
    } lock_cmd_t;

    typedef enum {
        DRAIN_FREE,
        DRAIN_HALF,
        DRAIN_SLOW
    } drain_mode_t;

    logic                    clk             = 1'b0;
    logic                    rst_n           = 1'b0;
    logic                    cfg_wr_en       = 1'b0;
    logic [LOCK_COUNT_W-1:0] cfg_wr_data     = '0;
    logic                    push            = 1'b0;
    logic                    full;
    logic [OP_W-1:0]         operation       = '0;
    logic [LOCK_W-1:0]       lock_index      = '0;
    logic [REQ_W-1:0]        requester       = '0;
    logic                    last_of_request = 1'b0;
    logic                    empty;
    logic                    pop             = 1'b0;
    logic                    granted;
    logic [ERR_W-1:0]        error_code;
    logic                    all_granted;
    logic                    request_done;

    // predicted lock table
    logic                      lk_wr_locked [NUM_LOCKS];
    logic [REQ_W-1:0]          lk_writer    [NUM_LOCKS];
    logic [NUM_REQUESTERS-1:0] lk_readers   [NUM_LOCKS];
    logic [CNT_W-1:0]          lk_n_readers [NUM_LOCKS];
    logic                      req_all_ok;
    logic [LOCK_COUNT_W-1:0]   locks_in_use;

    lock_cmd_t   pending_q[$];
    lock_cmd_t   release_backlog[$];
    result_t     expected_q[$];
    int unsigned queued_items;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned drain_left = 0;
    drain_mode_t drain_mode = DRAIN_FREE;

    reader_writer_lock_table_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .lock_index      (lock_index),
        .requester       (requester),
        .last_of_request (last_of_request),
        .empty           (empty),
        .pop             (pop),
        .granted         (granted),
        .error_code      (error_code),
        .all_granted     (all_granted),
        .request_done    (request_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t apply_lock_cmd(lock_cmd_t c);
        int unsigned               lim;
        logic [NUM_REQUESTERS-1:0] who_mask;
        logic                      is_reader;
        result_t                   r;
        r   = '0;
        lim = (int'(locks_in_use) < NUM_LOCKS) ? int'(locks_in_use) : NUM_LOCKS;
        who_mask        = '0;
        who_mask[c.who] = 1'b1;
        if (int'(c.idx) >= lim) begin
            r.error_code = ERR_RANGE;
        end else begin
            is_reader = |(lk_readers[c.idx] & who_mask);
            case (c.op)
                OP_ACQ_RD:
                begin
                    // refused only when written with no readers left
                    if (!(lk_n_readers[c.idx] == '0 && lk_wr_locked[c.idx])) begin
                        if (!is_reader) begin
                            lk_readers[c.idx]   = lk_readers[c.idx] | who_mask;
                            lk_n_readers[c.idx] = lk_n_readers[c.idx] + 1'b1;
                        end
                        r.granted = 1'b1;
                    end
                end
                OP_ACQ_WR:
                begin
                    if (lk_n_readers[c.idx] == '0 || (lk_n_readers[c.idx] == 1 && is_reader)) begin
                        if (!lk_wr_locked[c.idx] || lk_writer[c.idx] == c.who) begin
                            lk_wr_locked[c.idx] = 1'b1;
                            lk_writer[c.idx]    = c.who;
                            r.granted           = 1'b1;
                        end
                    end
                end
                OP_REL_RD:
                begin
                    if (!is_reader) begin
                        r.error_code = ERR_NOT_READER;
                    end else begin
                        lk_readers[c.idx] = lk_readers[c.idx] & ~who_mask;
                        if (lk_n_readers[c.idx] != '0)
                            lk_n_readers[c.idx] = lk_n_readers[c.idx] - 1'b1;
                        // last reader out drops the write flag, writer id stays
                        if (lk_n_readers[c.idx] == '0)
                            lk_wr_locked[c.idx] = 1'b0;
                        r.granted = 1'b1;
                    end
                end
                default:
                begin
                    if (!lk_wr_locked[c.idx] || lk_writer[c.idx] != c.who) begin
                        r.error_code = ERR_NOT_WRITER;
                    end else begin
                        lk_wr_locked[c.idx] = 1'b0;
                        lk_writer[c.idx]    = '0;
                        r.granted           = 1'b1;
                    end
                end
            endcase
        end
        // only acquires can spoil a request; releases never clear it
        if ((c.op == OP_ACQ_RD || c.op == OP_ACQ_WR) && !r.granted)
            req_all_ok = 1'b0;
        if (c.last) begin
            r.all_granted = req_all_ok;
            req_all_ok    = 1'b1;
        end
        r.request_done = c.last;
        return r;
    endfunction

    task automatic add_item(op_t op, int unsigned idx, int unsigned who, int unsigned last);
        lock_cmd_t c;
        c.op   = op;
        c.idx  = idx[LOCK_W-1:0];
        c.who  = who[REQ_W-1:0];
        c.last = last[0];
        pending_q.push_back(c);
        queued_items++;
    endtask

    function automatic int unsigned pick_lock(int unsigned hot_base, int unsigned hot_span);
        int unsigned lim;
        int unsigned roll;
        lim  = (int'(locks_in_use) < NUM_LOCKS) ? int'(locks_in_use) : NUM_LOCKS;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return hot_base + $urandom_range(0, hot_span - 1);
        else if (roll < 92)
            return $urandom_range(0, lim - 1);
        else
            return $urandom_range(0, NUM_LOCKS - 1);
    endfunction

    // one multi-lock request: read ids first, then write ids; releases kept for later
    task automatic queue_request(int unsigned hot_base, int unsigned hot_span);
        int unsigned who;
        int unsigned n_rd;
        int unsigned n_wr;
        int unsigned idx;
        int unsigned last_rd;
        lock_cmd_t   rel;
        who     = $urandom_range(0, NUM_REQUESTERS - 1);
        n_rd    = $urandom_range(0, 3);
        n_wr    = $urandom_range(0, 2);
        last_rd = pick_lock(hot_base, hot_span);
        if (n_rd + n_wr == 0)
            n_rd = 1;
        for (int i = 0; i < n_rd; i++) begin
            idx     = pick_lock(hot_base, hot_span);
            last_rd = idx;
            add_item(OP_ACQ_RD, idx, who, (i == n_rd - 1 && n_wr == 0));
            rel.op  = OP_REL_RD;
            rel.idx = idx[LOCK_W-1:0];
            rel.who = who[REQ_W-1:0];
            release_backlog.push_back(rel);
        end
        for (int i = 0; i < n_wr; i++) begin
            // often upgrade a lock just read
            idx = ($urandom_range(0, 9) < 4) ? last_rd : pick_lock(hot_base, hot_span);
            add_item(OP_ACQ_WR, idx, who, (i == n_wr - 1));
            rel.op  = OP_REL_WR;
            rel.idx = idx[LOCK_W-1:0];
            rel.who = who[REQ_W-1:0];
            release_backlog.push_back(rel);
        end
    endtask

    task automatic queue_releases();
        int unsigned count;
        int unsigned pos;
        lock_cmd_t   rel;
        count = $urandom_range(1, (release_backlog.size() < 6) ? release_backlog.size() : 6);
        for (int unsigned k = 0; k < count; k++) begin
            pos = $urandom_range(0, release_backlog.size() - 1);
            rel = release_backlog[pos];
            release_backlog.delete(pos);
            add_item(rel.op, rel.idx, rel.who, (k == count - 1) ? $urandom_range(0, 1) : 0);
        end
    endtask

    task automatic write_lock_count(int unsigned value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[LOCK_COUNT_W-1:0];
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        locks_in_use = value[LOCK_COUNT_W-1:0];
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sender: bursts of random length, each preceded by a random gap that may be empty
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full) begin
                expected_q.push_back(apply_lock_cmd(pending_q.pop_front()));
                if (burst_left > 0)
                    burst_left--;
            end
            if (burst_left == 0) begin
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
            end
            if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (pending_q.size() > 0) begin
                push            <= 1'b1;
                operation       <= pending_q[0].op;
                lock_index      <= pending_q[0].idx;
                requester       <= pending_q[0].who;
                last_of_request <= pending_q[0].last;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // receiver: check each transfer, stall in stretches of changing pressure
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n) begin
            if (pop && !empty) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    mismatches++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (granted !== exp_r.granted) begin
                        $error("granted: expected %0d, got %0d", exp_r.granted, granted);
                        mismatches++;
                    end
                    if (error_code !== exp_r.error_code) begin
                        $error("error_code: expected %0d, got %0d", exp_r.error_code, error_code);
                        mismatches++;
                    end
                    if (all_granted !== exp_r.all_granted) begin
                        $error("all_granted: expected %0d, got %0d",
                               exp_r.all_granted, all_granted);
                        mismatches++;
                    end
                    if (request_done !== exp_r.request_done) begin
                        $error("request_done: expected %0d, got %0d",
                               exp_r.request_done, request_done);
                        mismatches++;
                    end
                end
            end
            if (drain_left == 0) begin
                drain_mode = drain_mode_t'($urandom_range(0, 2));
                drain_left = $urandom_range(8, 60);
            end
            drain_left--;
            case (drain_mode)
                DRAIN_FREE: pop <= 1'b1;
                DRAIN_HALF: pop <= ($urandom_range(0, 1) == 1);
                default:    pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int unsigned lim;
        int unsigned hot_span;
        int unsigned hot_base;
        int unsigned roll;
        for (int i = 0; i < NUM_LOCKS; i++) begin
            lk_wr_locked[i] = 1'b0;
            lk_writer[i]    = '0;
            lk_readers[i]   = '0;
            lk_n_readers[i] = '0;
        end
        req_all_ok   = 1'b1;
        locks_in_use = LOCK_COUNT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset config, all 64 locks in use
        add_item(OP_ACQ_RD, 0, 0, 0);
        add_item(OP_ACQ_RD, 0, 0, 0);     // same reader again, not counted twice
        add_item(OP_ACQ_WR, 0, 0, 1);     // sole reader upgrades
        add_item(OP_ACQ_RD, 0, 15, 0);    // write-locked but readers present
        add_item(OP_ACQ_WR, 0, 15, 1);    // two readers: refused
        add_item(OP_REL_WR, 0, 15, 0);    // not the writer
        add_item(OP_REL_WR, 0, 0, 0);
        add_item(OP_REL_RD, 63, 9, 0);    // reader not holding
        add_item(OP_ACQ_WR, 63, 15, 0);
        add_item(OP_ACQ_WR, 63, 15, 0);   // same writer again
        add_item(OP_ACQ_RD, 63, 3, 0);    // written, no readers: refused
        add_item(OP_ACQ_WR, 63, 3, 0);
        add_item(OP_REL_WR, 63, 15, 1);   // release does not restore the request flag
        add_item(OP_REL_RD, 0, 0, 0);
        add_item(OP_REL_RD, 0, 15, 1);
        add_item(OP_ACQ_RD, 42, 2, 0);
        add_item(OP_ACQ_WR, 42, 2, 0);
        add_item(OP_REL_RD, 42, 2, 0);    // last reader out clears the write flag
        add_item(OP_REL_WR, 42, 2, 1);
        wait_drained();

        write_lock_count(1);
        add_item(OP_ACQ_RD, 1, 4, 0);     // out of range spoils the request
        add_item(OP_REL_RD, 0, 4, 0);
        add_item(OP_ACQ_RD, 0, 4, 1);
        add_item(OP_ACQ_WR, 63, 4, 1);
        add_item(OP_REL_RD, 0, 4, 1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_lock_count(LOCK_COUNT_PLAN[p]);
            lim          = (int'(locks_in_use) < NUM_LOCKS) ? int'(locks_in_use) : NUM_LOCKS;
            hot_span     = (lim < 4) ? lim : 4;
            hot_base     = $urandom_range(0, lim - hot_span);
            queued_items = 0;
            while (queued_items < ITEMS_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                if (release_backlog.size() > 32 || (roll >= 50 && roll < 80 &&
                                                     release_backlog.size() > 0))
                    queue_releases();
                else if (roll < 80)
                    queue_request(hot_base, hot_span);
                else
                    add_item(op_t'($urandom_range(0, 3)), $urandom_range(0, NUM_LOCKS - 1),
                             $urandom_range(0, NUM_REQUESTERS - 1), $urandom_range(0, 1));
            end
        end

        wait_drained();
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
